@@ hdl/ppts_pkg.sv @@
// Shared types, constants and helpers for the perspective projection block.
package ppts_pkg;

  localparam int QD = 4;
  localparam int QAW = 2;
  localparam int QCW = 3;
  localparam int NBITS = 63;
  localparam int DBITS = 31;
  localparam logic signed [31:0] W_MIN = 32'sd66;
  localparam logic signed [17:0] BEHIND_SCALE = 18'sd100000;

  localparam logic [3:0] REG_XROW0 = 4'd0;
  localparam logic [3:0] REG_XROW1 = 4'd1;
  localparam logic [3:0] REG_YROW0 = 4'd2;
  localparam logic [3:0] REG_YROW1 = 4'd3;
  localparam logic [3:0] REG_WROW0 = 4'd4;
  localparam logic [3:0] REG_WROW1 = 4'd5;
  localparam logic [3:0] REG_SCR_W = 4'd6;
  localparam logic [3:0] REG_SCR_H = 4'd7;

  typedef struct packed {
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
    logic signed [31:0] world_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic               in_front;
  } out_t;

  typedef struct packed {
    logic [2:0][3:0][31:0] m;
    logic [13:0]           scr_w;
    logic [13:0]           scr_h;
  } cfg_t;

  typedef struct packed {
    logic              front;
    logic              negx;
    logic              negy;
    logic [DBITS-1:0]  den;
    logic [NBITS-1:0]  nx;
    logic [NBITS-1:0]  ny;
    logic [31:0]       bx;
    logic [31:0]       by;
  } mid_t;

  typedef struct packed {
    logic              front;
    logic              negx;
    logic              negy;
    logic              ovx;
    logic              ovy;
    logic [DBITS-1:0]  den;
    logic [DBITS-1:0]  remx;
    logic [DBITS-1:0]  remy;
    logic [DBITS-1:0]  lowx;
    logic [DBITS-1:0]  lowy;
    logic [DBITS-1:0]  qx;
    logic [DBITS-1:0]  qy;
    logic [31:0]       bx;
    logic [31:0]       by;
  } div_t;

  function automatic logic [31:0] sat32(input logic signed [50:0] v);
    logic [31:0] r;
    if (v > 51'sd2147483647) begin
      r = 32'h7fff_ffff;
    end else if (v < -51'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ hdl/ppts_front.sv @@
// Front pipeline: row products, dot sums, behind check and divide operands.
module ppts_front import ppts_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_push,
  output logic  in_full,
  input  in_t   in_data,
  input  cfg_t  cfg,
  input  logic  mq_full,
  output logic  mq_push,
  output mid_t  mq_data
);

  logic [3:0]         vld_r;
  logic               adv;
  logic signed [63:0] prod_r [3][3];
  logic [31:0]        dot_r [3];
  logic               behind_r;
  logic signed [49:0] bxp_r, byp_r;
  logic signed [47:0] mx_r, my_r;
  logic [31:0]        w_r;
  mid_t               mid_r;
  logic signed [31:0] coord [3];
  logic signed [50:0] sum [3];
  logic signed [32:0] ax, ay;
  logic [47:0]        magx, magy;

  assign adv     = !(vld_r[3] && mq_full);
  assign in_full = !adv;
  assign mq_push = vld_r[3] && !mq_full;
  assign mq_data = mid_r;

  assign coord[0] = in_data.world_x;
  assign coord[1] = in_data.world_y;
  assign coord[2] = in_data.world_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[2:0], in_push};
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum[r] = $signed({{3{prod_r[r][0][63]}}, prod_r[r][0][63:16]})
             + $signed({{3{prod_r[r][1][63]}}, prod_r[r][1][63:16]})
             + $signed({{3{prod_r[r][2][63]}}, prod_r[r][2][63:16]})
             + $signed({{19{cfg.m[r][3][31]}}, cfg.m[r][3]});
    end
    ax = $signed({dot_r[2][31], dot_r[2]}) + $signed({dot_r[0][31], dot_r[0]});
    ay = $signed({dot_r[2][31], dot_r[2]}) - $signed({dot_r[1][31], dot_r[1]});
    magx = mx_r[47] ? 48'(-mx_r) : mx_r;
    magy = my_r[47] ? 48'(-my_r) : my_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_r[r][c] <= $signed(cfg.m[r][c]) * coord[c];
        end
        dot_r[r] <= sat32(sum[r]);
      end
      behind_r <= $signed(dot_r[2]) < W_MIN;
      bxp_r    <= $signed(dot_r[0]) * BEHIND_SCALE;
      byp_r    <= $signed(dot_r[1]) * BEHIND_SCALE;
      mx_r     <= $signed({1'b0, cfg.scr_w}) * ax;
      my_r     <= $signed({1'b0, cfg.scr_h}) * ay;
      w_r      <= dot_r[2];
      mid_r.front <= !behind_r;
      mid_r.negx  <= mx_r[47];
      mid_r.negy  <= my_r[47];
      mid_r.den   <= w_r[DBITS-1:0];
      mid_r.nx    <= {1'b0, magx[46:0], 15'd0} + NBITS'(w_r[DBITS-1:1]);
      mid_r.ny    <= {1'b0, magy[46:0], 15'd0} + NBITS'(w_r[DBITS-1:1]);
      mid_r.bx    <= sat32(51'(bxp_r));
      mid_r.by    <= sat32(51'(byp_r));
    end
  end

endmodule

@@ hdl/ppts_midq.sv @@
// Short queue between the front and back pipelines.
module ppts_midq import ppts_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  mid_t  wdata,
  output logic  full,
  input  logic  pop,
  output mid_t  rdata,
  output logic  empty
);

  mid_t            mem [QD];
  logic [QAW-1:0]  wp_r, rp_r;
  logic [QCW-1:0]  cnt_r;

  assign full  = cnt_r == QCW'(QD);
  assign empty = cnt_r == '0;
  assign rdata = mem[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + QCW'(push) - QCW'(pop);
    end
  end

endmodule

@@ hdl/ppts_back.sv @@
// Back pipeline: bit-per-stage divider, result select and output queue.
module ppts_back import ppts_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  mq_empty,
  input  mid_t  mq_data,
  output logic  mq_pop,
  output logic  out_empty,
  input  logic  out_pop,
  output out_t  out_data
);

  logic [DBITS:0]  vld_r;
  div_t            dv_r [DBITS];
  div_t            dv_in;
  out_t            res_r;
  logic            adv;
  out_t            oq [QD];
  logic [QAW-1:0]  wp_r, rp_r;
  logic [QCW-1:0]  cnt_r;
  logic            oq_full, oq_push, oq_pop;
  logic [31:0]     selx, sely;

  function automatic div_t div_step(input div_t d);
    div_t        n;
    logic [DBITS:0] tx, ty;
    n  = d;
    tx = {d.remx, d.lowx[DBITS-1]};
    ty = {d.remy, d.lowy[DBITS-1]};
    n.lowx = {d.lowx[DBITS-2:0], 1'b0};
    n.lowy = {d.lowy[DBITS-2:0], 1'b0};
    if (tx >= {1'b0, d.den}) begin
      n.remx = DBITS'(tx - {1'b0, d.den});
      n.qx   = {d.qx[DBITS-2:0], 1'b1};
    end else begin
      n.remx = tx[DBITS-1:0];
      n.qx   = {d.qx[DBITS-2:0], 1'b0};
    end
    if (ty >= {1'b0, d.den}) begin
      n.remy = DBITS'(ty - {1'b0, d.den});
      n.qy   = {d.qy[DBITS-2:0], 1'b1};
    end else begin
      n.remy = ty[DBITS-1:0];
      n.qy   = {d.qy[DBITS-2:0], 1'b0};
    end
    return n;
  endfunction

  assign oq_full  = cnt_r == QCW'(QD);
  assign adv      = !(vld_r[DBITS] && oq_full);
  assign mq_pop   = adv && !mq_empty;
  assign oq_push  = vld_r[DBITS] && !oq_full;
  assign oq_pop   = out_pop && !out_empty;
  assign out_empty = cnt_r == '0;
  assign out_data = oq[rp_r];

  always_comb begin
    dv_in.front = mq_data.front;
    dv_in.negx  = mq_data.negx;
    dv_in.negy  = mq_data.negy;
    dv_in.ovx   = mq_data.nx >= {1'b0, mq_data.den, {DBITS{1'b0}}};
    dv_in.ovy   = mq_data.ny >= {1'b0, mq_data.den, {DBITS{1'b0}}};
    dv_in.den   = mq_data.den;
    dv_in.remx  = mq_data.nx[2*DBITS-1:DBITS];
    dv_in.remy  = mq_data.ny[2*DBITS-1:DBITS];
    dv_in.lowx  = mq_data.nx[DBITS-1:0];
    dv_in.lowy  = mq_data.ny[DBITS-1:0];
    dv_in.qx    = '0;
    dv_in.qy    = '0;
    dv_in.bx    = mq_data.bx;
    dv_in.by    = mq_data.by;
  end

  always_comb begin
    if (dv_r[DBITS-1].ovx) begin
      selx = dv_r[DBITS-1].negx ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      selx = dv_r[DBITS-1].negx ? 32'(-{1'b0, dv_r[DBITS-1].qx}) : {1'b0, dv_r[DBITS-1].qx};
    end
    if (dv_r[DBITS-1].ovy) begin
      sely = dv_r[DBITS-1].negy ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      sely = dv_r[DBITS-1].negy ? 32'(-{1'b0, dv_r[DBITS-1].qy}) : {1'b0, dv_r[DBITS-1].qy};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[DBITS-1:0], mq_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_r[0] <= div_step(dv_in);
      for (int i = 1; i < DBITS; i++) begin
        dv_r[i] <= div_step(dv_r[i-1]);
      end
      res_r.in_front <= dv_r[DBITS-1].front;
      res_r.screen_x <= dv_r[DBITS-1].front ? selx : dv_r[DBITS-1].bx;
      res_r.screen_y <= dv_r[DBITS-1].front ? sely : dv_r[DBITS-1].by;
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq[wp_r] <= res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (oq_push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (oq_pop) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + QCW'(oq_push) - QCW'(oq_pop);
    end
  end

endmodule

@@ hdl/perspective_project_to_screen.sv @@
// Top level: configuration registers and the front, queue and back parts.
// Path: an input beat passes the front pipeline, the mid queue, the divider
// stages, a result register and the output queue.
// Throughput: one beat per cycle unless a full output queue stalls the
// pipelines; the back part divides one quotient bit per stage over 31 stages,
// and every multiply sits in its own stage. Reset (rst_n low, synchronous):
// queues and pipelines empty, matrix zero, screen size 1920 by 1080.
module perspective_project_to_screen import ppts_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  in_t         in_data,
  output logic        out_empty,
  input  logic        out_pop,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_idx,
  input  logic [63:0] cfg_data
);

  logic [63:0] xrow0_r, xrow1_r, yrow0_r, yrow1_r, wrow0_r, wrow1_r;
  logic [13:0] scr_w_r, scr_h_r;
  cfg_t        cfg;
  logic        mq_push, mq_full, mq_pop, mq_empty;
  mid_t        mq_wdata, mq_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xrow0_r <= '0;
      xrow1_r <= '0;
      yrow0_r <= '0;
      yrow1_r <= '0;
      wrow0_r <= '0;
      wrow1_r <= '0;
      scr_w_r <= 14'd1920;
      scr_h_r <= 14'd1080;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_XROW0: xrow0_r <= cfg_data;
        REG_XROW1: xrow1_r <= cfg_data;
        REG_YROW0: yrow0_r <= cfg_data;
        REG_YROW1: yrow1_r <= cfg_data;
        REG_WROW0: wrow0_r <= cfg_data;
        REG_WROW1: wrow1_r <= cfg_data;
        REG_SCR_W: scr_w_r <= cfg_data[13:0];
        REG_SCR_H: scr_h_r <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.m[0] = {xrow1_r[63:32], xrow1_r[31:0], xrow0_r[63:32], xrow0_r[31:0]};
    cfg.m[1] = {yrow1_r[63:32], yrow1_r[31:0], yrow0_r[63:32], yrow0_r[31:0]};
    cfg.m[2] = {wrow1_r[63:32], wrow1_r[31:0], wrow0_r[63:32], wrow0_r[31:0]};
    cfg.scr_w = scr_w_r;
    cfg.scr_h = scr_h_r;
  end

  ppts_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_data (in_data),
    .cfg     (cfg),
    .mq_full (mq_full),
    .mq_push (mq_push),
    .mq_data (mq_wdata)
  );

  ppts_midq u_midq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mq_push),
    .wdata (mq_wdata),
    .full  (mq_full),
    .pop   (mq_pop),
    .rdata (mq_rdata),
    .empty (mq_empty)
  );

  ppts_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mq_empty  (mq_empty),
    .mq_data   (mq_rdata),
    .mq_pop    (mq_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

@@ tb/sv/perspective_project_to_screen_tb.sv @@
// Testbench for the perspective projection block: directed table, random points, predictor.
module perspective_project_to_screen_tb;
  import ppts_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  in_t         in_data = '0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  out_t        out_data;
  logic        cfg_we = 1'b0;
  logic [3:0]  cfg_idx = '0;
  logic [63:0] cfg_data = '0;

  perspective_project_to_screen i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [63:0] mat_reg [6];
  logic [13:0] scr_w, scr_h;
  out_t        pending_points [$];
  int          mismatches = 0;
  int          beats_in = 0, beats_out = 0, front_count = 0;
  int          send_idle_pct = 0, recv_stall_pct = 0;
  bit          hold_off = 1'b0;

  function automatic logic signed [63:0] q_mul(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return p >>> 16;
  endfunction

  function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic signed [63:0] row_sum(input int r, input in_t p);
    logic signed [63:0] s;
    s = q_mul(mat_reg[2*r][31:0], p.world_x) + q_mul(mat_reg[2*r][63:32], p.world_y)
      + q_mul(mat_reg[2*r+1][31:0], p.world_z) + 64'($signed(mat_reg[2*r+1][63:32]));
    return clamp32(s);
  endfunction

  function automatic logic signed [63:0] to_pixels(input logic [13:0] size,
                                                   input logic signed [63:0] a,
                                                   input logic signed [63:0] w);
    logic signed [95:0] num, mag, q;
    num = 96'($signed({1'b0, size})) * 96'(a) * 96'sd32768;
    mag = (num < 0) ? -num : num;
    q = (mag + 96'(w) / 2) / 96'(w);
    if (num < 0) q = -q;
    if (q > 96'sd2147483647) return 64'sd2147483647;
    if (q < -96'sd2147483648) return -64'sd2147483648;
    return 64'(q);
  endfunction

  function automatic out_t project_point(input in_t p);
    logic signed [63:0] cx, cy, w;
    out_t r;
    cx = row_sum(0, p);
    cy = row_sum(1, p);
    w = row_sum(2, p);
    if (w < 64'(W_MIN)) begin
      r.screen_x = 32'(clamp32(cx * 100000));
      r.screen_y = 32'(clamp32(cy * 100000));
      r.in_front = 1'b0;
    end else begin
      r.screen_x = 32'(to_pixels(scr_w, w + cx, w));
      r.screen_y = 32'(to_pixels(scr_h, w - cy, w));
      r.in_front = 1'b1;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s at beat %0d: got %h want %h", what, beats_out, got, want);
    mismatches++;
  endtask

  task automatic write_reg(input logic [3:0] idx, input logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx < REG_SCR_W) mat_reg[idx] = val;
    else if (idx == REG_SCR_W) scr_w = val[13:0];
    else if (idx == REG_SCR_H) scr_h = val[13:0];
  endtask

  // push one beat; expectation queued when accepted
  task automatic send_point(input in_t p, input bit typed, input out_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= p;
    @(posedge clk);
    while (in_full) @(posedge clk);
    pending_points = {pending_points, typed ? want : project_point(p)};
    beats_in++;
  endtask

  task automatic drain();
    int n;
    n = 0;
    in_push <= 1'b0;
    while (pending_points.size() != 0 && n < 200000) begin
      @(posedge clk);
      n++;
    end
    repeat (60) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (pending_points.size() == 0) begin
        report_mismatch("unexpected beat", out_data.screen_x, 32'h0);
      end else begin
        out_t e;
        e = pending_points.pop_front();
        if (out_data.screen_x !== e.screen_x)
          report_mismatch("screen_x", out_data.screen_x, e.screen_x);
        if (out_data.screen_y !== e.screen_y)
          report_mismatch("screen_y", out_data.screen_y, e.screen_y);
        if (out_data.in_front !== e.in_front)
          report_mismatch("in_front", 32'(out_data.in_front), 32'(e.in_front));
        front_count += e.in_front;
      end
      beats_out++;
    end
    out_pop <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic logic [31:0] rand_coord();
    unique case ($urandom_range(5))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
      2: return {$urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff};
      default: return 32'($signed($urandom_range(0, 2000 << 16)) - (1000 << 16));
    endcase
  endfunction

  function automatic logic [31:0] rand_elem();
    unique case ($urandom_range(4))
      0: return $urandom;
      1: return 32'h0001_0000;
      default: return 32'($signed($urandom_range(0, 4 << 16)) - (2 << 16));
    endcase
  endfunction

  typedef struct {
    in_t  p;
    bit   typed;
    out_t want;
  } row_t;

  initial begin
    row_t table_rows [12];
    in_t  p;
    logic [13:0] sizes [4] = '{14'd0, 14'd16383, 14'd1920, 14'd640};
    rst_n = 1'b0;
    for (int i = 0; i < 6; i++) mat_reg[i] = '0;
    scr_w = 14'd1920;
    scr_h = 14'd1080;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero matrix after reset: every point behind at origin
    table_rows[0] = '{'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, 1, '{0, 0, 0}};
    table_rows[1] = '{'{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff}, 1, '{0, 0, 0}};
    table_rows[2] = '{'{32'hffff_ffff, 32'h0, 32'h5555_aaaa}, 1, '{0, 0, 0}};
    for (int i = 0; i < 3; i++) send_point(table_rows[i].p, 1, table_rows[i].want);
    drain();

    // identity-like: w = world_z; around the threshold and extremes
    write_reg(REG_XROW0, {32'h0, 32'h0001_0000});
    write_reg(REG_XROW1, 64'h0);
    write_reg(REG_YROW0, {32'h0001_0000, 32'h0});
    write_reg(REG_YROW1, 64'h0);
    write_reg(REG_WROW0, 64'h0);
    write_reg(REG_WROW1, {32'h0, 32'h0001_0000});
    for (int t = 0; t < 9; t++) begin
      table_rows[t].p = '{32'h7fff_ffff, 32'h8000_0000, 32'd65 + t[31:0]};
      table_rows[t].typed = 0;
      table_rows[t].want = '0;
    end
    table_rows[9].p = '{32'h0, 32'h0, 32'h8000_0000};
    table_rows[10].p = '{32'h0001_0000, 32'hffff_0000, 32'h7fff_ffff};
    table_rows[11].p = '{32'hffff_8000, 32'h0000_8000, 32'h0001_0000};
    for (int t = 9; t < 12; t++) table_rows[t].typed = 0;
    for (int t = 0; t < 12; t++) begin
      p = table_rows[t].p;
      // w takes world_z via the third column only when row 2 col 2 (WROW1 low word) is set
      send_point(p, 0, '0);
    end
    drain();
    write_reg(REG_WROW1, {32'h0, 32'h0});
    write_reg(REG_WROW1, {32'h0, 32'h0001_0000});
    write_reg(4'd8, 64'hffff_ffff_ffff_ffff);
    write_reg(4'd15, 64'h0);

    for (int ph = 0; ph < 12; ph++) begin
      unique case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      for (int i = 0; i < 6; i++) write_reg(i[3:0], {rand_elem(), rand_elem()});
      if ($urandom_range(1)) write_reg(REG_WROW1, {32'h0001_0000, rand_elem()});
      write_reg(REG_SCR_W, {$urandom, 18'h0, sizes[ph % 4]});
      write_reg(REG_SCR_H, {$urandom, 18'h0, sizes[(ph + 1) % 4]});
      if (ph == 2) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (300) @(posedge clk);
            hold_off = 1'b0;
          end
        join_none
      end
      for (int k = 0; k < 125; k++) begin
        p.world_x = rand_coord();
        p.world_y = rand_coord();
        p.world_z = rand_coord();
        send_point(p, 0, '0);
      end
      drain();
    end

    $display("covered %0d points in, %0d results out, %0d in front of the viewer",
             beats_in, beats_out, front_count);
    $display("phases: reset defaults, threshold edge, random matrices, four idle mixes");
    if (mismatches == 0 && pending_points.size() == 0) begin
      $display("[perspective_project_to_screen] OK");
    end else begin
      $display("[perspective_project_to_screen] ERROR");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("[perspective_project_to_screen] ERROR");
    $finish;
  end

endmodule

@@ sim.f @@
hdl/ppts_pkg.sv
hdl/ppts_front.sv
hdl/ppts_midq.sv
hdl/ppts_back.sv
hdl/perspective_project_to_screen.sv
tb/sv/perspective_project_to_screen_tb.sv
